// ===== rtl/srm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse table range maximum: shared definitions
// Field widths, operation and status codes and parameter defaults.
// ----------------------------------------------------------------------------
package srm_pkg;

  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned LEVELS_DEF     = 11;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned LEN_W   = INDEX_W + 1;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

endpackage

// ===== rtl/srm_if.sv =====
// ----------------------------------------------------------------------------
// Sparse table range maximum: channel interfaces
// Request channel (append or query) and result channel, valid/ready.
// ----------------------------------------------------------------------------
interface srm_in_if
  import srm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [VALUE_W-1:0] value;
  logic        [INDEX_W-1:0] left;
  logic        [INDEX_W-1:0] right;

  modport source (output valid, op, value, left, right, input ready);
  modport sink   (input valid, op, value, left, right, output ready);
endinterface

interface srm_out_if
  import srm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] max_value;
  status_e                   status;

  modport source (output valid, max_value, status, input ready);
  modport sink   (input valid, max_value, status, output ready);
endinterface

// ===== rtl/srm_mem.sv =====
// ----------------------------------------------------------------------------
// Sparse table range maximum: window table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srm_mem #(
  parameter int unsigned DW = 32,
  parameter int unsigned AW = 14,
  parameter int unsigned ENTRIES = 11264
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/srm_seq.sv =====
// ----------------------------------------------------------------------------
// Sparse table range maximum: sequencer and compare unit
// Walks the table levels on an append and the two windows of a query,
// sharing one signed comparator and the single table read port.
// ----------------------------------------------------------------------------
module srm_seq
  import srm_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned LEVELS     = LEVELS_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned IW         = $clog2(DEPTH),
  parameter int unsigned LW         = $clog2(LEVELS),
  parameter int unsigned AW         = LW + IW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      op_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic        [INDEX_W-1:0] left_i,
  input  logic        [INDEX_W-1:0] right_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic [DATA_WIDTH-1:0]     res_value_o,
  output status_e                   res_status_o,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [DATA_WIDTH-1:0]     mem_wdata_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]     mem_rdata_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned JW = $clog2(LEVELS + 1);
  localparam int unsigned SW = IW + 2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LVL  = 8'b0000_0010,
    S_MAX  = 8'b0000_0100,
    S_LOG  = 8'b0000_1000,
    S_QA   = 8'b0001_0000,
    S_QB   = 8'b0010_0000,
    S_QM   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         l_q, l_d;
  logic [IW-1:0]         r_q, r_d;
  logic [JW-1:0]         j_q, j_d;
  logic [SW-1:0]         span_q, span_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [DATA_WIDTH-1:0] prev_q, prev_d;
  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] res_val_q, res_val_d;
  status_e               res_st_q, res_st_d;

  logic [DATA_WIDTH-1:0] value_ext;
  logic [DATA_WIDTH-1:0] cmp_a, cmp_b, cmp_max;
  logic [SW-1:0]         idx_end;
  logic [IW-1:0]         start;
  logic [IW-1:0]         second;
  logic                  bad_range;

  assign value_ext = DATA_WIDTH'(value_i);
  assign idx_end   = SW'(idx_q) + SW'(1);
  assign start     = IW'(idx_end - span_q);
  assign second    = IW'(SW'(r_q) + SW'(1) - span_q);
  assign bad_range = (left_i > right_i) || (32'(right_i) >= 32'(count_q));

  assign cmp_a   = (state_q == S_MAX) ? prev_q : a_q;
  assign cmp_b   = mem_rdata_i;
  assign cmp_max = ($signed(cmp_a) >= $signed(cmp_b)) ? cmp_a : cmp_b;

  assign in_ready_o   = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_value_o  = res_val_q;
  assign res_status_o = res_st_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    l_d         = l_q;
    r_d         = r_q;
    j_d         = j_q;
    span_d      = span_q;
    len_d       = len_q;
    prev_d      = prev_q;
    a_d         = a_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = cmp_max;
    mem_raddr_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_val_d = '0;
          res_st_d  = ST_OK;
          if (op_i == OP_APPEND) begin
            if (count_q == CW'(DEPTH)) begin
              res_st_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = {LW'(0), count_q[IW-1:0]};
              mem_wdata_o = value_ext;
              prev_d      = value_ext;
              idx_d       = count_q[IW-1:0];
              count_d     = count_q + CW'(1);
              j_d         = JW'(1);
              span_d      = SW'(2);
              state_d     = S_LVL;
            end
          end else begin
            if (bad_range) begin
              res_st_d = ST_RANGE;
              state_d  = S_DONE;
            end else begin
              l_d     = IW'(left_i);
              r_d     = IW'(right_i);
              len_d   = LEN_W'(right_i) - LEN_W'(left_i) + LEN_W'(1);
              j_d     = '0;
              span_d  = SW'(1);
              state_d = S_LOG;
            end
          end
        end
      end
      S_LVL: begin
        if ((j_q == JW'(LEVELS)) || (span_q > idx_end)) begin
          state_d = S_DONE;
        end else begin
          mem_raddr_o = {LW'(j_q - JW'(1)), start};
          state_d     = S_MAX;
        end
      end
      S_MAX: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = {LW'(j_q), start};
        prev_d      = cmp_max;
        j_d         = j_q + JW'(1);
        span_d      = span_q << 1;
        state_d     = S_LVL;
      end
      S_LOG: begin
        if ((len_q > LEN_W'(1)) && (j_q != JW'(LEVELS - 1))) begin
          len_d  = len_q >> 1;
          j_d    = j_q + JW'(1);
          span_d = span_q << 1;
        end else begin
          state_d = S_QA;
        end
      end
      S_QA: begin
        mem_raddr_o = {LW'(j_q), l_q};
        state_d     = S_QB;
      end
      S_QB: begin
        mem_raddr_o = {LW'(j_q), second};
        a_d         = mem_rdata_i;
        state_d     = S_QM;
      end
      S_QM: begin
        res_val_d = cmp_max;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    l_q       <= l_d;
    r_q       <= r_d;
    j_q       <= j_d;
    span_q    <= span_d;
    len_q     <= len_d;
    prev_q    <= prev_d;
    a_q       <= a_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("Element count exceeds the table depth.");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == OP_APPEND) && (count_q == CW'(DEPTH)))
    |=> $stable(count_q))
    else $error("Append to a full table changed the element count.");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> ((state_q == S_IDLE) || (state_q == S_MAX)))
    else $error("Table written outside an append.");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_status_o != ST_OK)) |-> (res_value_o == '0))
    else $error("Failed operation carries a non-zero maximum.");

endmodule

// ===== rtl/sparse_table_range_max.sv =====
// ----------------------------------------------------------------------------
// Sparse table range maximum: top level
// Builds a sparse table of signed values one append at a time and answers
// range maximum queries from it.
//
// Requests arrive on in_i: op 0 appends value at the next index, op 1 asks
// for the maximum over left..right. Every request gives exactly one result
// on out_o with a status of ok, table full or bad range.
// Requests are handled one at a time through a single table read port and
// one signed comparator. An append writes the new value to level 0, then
// fills each upper level whose window ends at it (at most LEVELS - 1); a
// query over n elements finds min(floor(log2 n), LEVELS - 1), the log being
// found by shifting the length one bit a cycle, then reads both windows and
// compares them. Rejected requests go straight to the result.
// The result sits in an output register, so the sequencer returns to idle
// and takes the next request while a result waits; if the receiver stalls
// longer, the next result is held in the sequencer and in_i.ready stays low.
// Reset empties the table by clearing the element count; the table memory
// itself is not cleared, and no entry is read before it is written.
// ----------------------------------------------------------------------------
module sparse_table_range_max
  import srm_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned LEVELS     = LEVELS_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  srm_in_if.sink    in_i,
  srm_out_if.source out_o
);

  localparam int unsigned IW      = $clog2(DEPTH);
  localparam int unsigned LW      = $clog2(LEVELS);
  localparam int unsigned AW      = LW + IW;
  localparam int unsigned ENTRIES = LEVELS * (2 ** IW);
  localparam int unsigned OW      = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic                  res_valid;
  logic                  res_ready;
  logic [DATA_WIDTH-1:0] res_value;
  status_e               res_status;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]    out_val_q;
  status_e               out_st_q;
  logic                  load;

  srm_seq #(
    .DEPTH      (DEPTH),
    .LEVELS     (LEVELS),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW),
    .LW         (LW),
    .AW         (AW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .op_i         (in_i.op),
    .value_i      (in_i.value),
    .left_i       (in_i.left),
    .right_i      (in_i.right),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_value_o  (res_value),
    .res_status_o (res_status),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  srm_mem #(
    .DW      (DATA_WIDTH),
    .AW      (AW),
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_val_q <= VALUE_W'(res_value[OW-1:0]);
      out_st_q  <= res_status;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.max_value = out_val_q;
  assign out_o.status    = out_st_q;

endmodule

// ===== dv/srm_result_checker.sv =====
// ----------------------------------------------------------------------------
// Sparse table range maximum: result checker
// Watches both channels, keeps its own copy of the sparse table and the
// element count, works out the answer for every request transfer and
// compares each result transfer with the oldest answer still outstanding.
// ----------------------------------------------------------------------------
module srm_result_checker
  import srm_pkg::*;
#(
  parameter int unsigned DEPTH  = DEPTH_DEF,
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srm_in_if           req_i,
  srm_out_if          rsp_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    status_e                   status;
  } answer_t;

  answer_t                   pending_answers[$];
  answer_t                   oldest;
  logic signed [VALUE_W-1:0] window_max[LEVELS][DEPTH];
  int unsigned               element_total;
  int unsigned               mismatches;

  function automatic logic signed [VALUE_W-1:0] greater(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    return (a >= b) ? a : b;
  endfunction

  function automatic answer_t answer_request(
    input logic                      op,
    input logic signed [VALUE_W-1:0] value,
    input logic        [INDEX_W-1:0] lo,
    input logic        [INDEX_W-1:0] hi
  );
    answer_t     ans;
    int unsigned idx;
    int unsigned span;
    int unsigned start;
    int unsigned len;
    int unsigned lvl;
    int unsigned second;
    ans.max_value = '0;
    ans.status    = ST_OK;
    if (op == OP_APPEND) begin
      if (element_total >= DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        idx = element_total;
        window_max[0][idx] = value;
        for (int j = 1; j < LEVELS; j++) begin
          span = 1 << j;
          if (span > idx + 1) break;
          start = idx + 1 - span;
          window_max[j][start] = greater(window_max[j-1][start],
                                         window_max[j-1][start + span / 2]);
        end
        element_total = idx + 1;
      end
    end else if (lo > hi || hi >= element_total) begin
      ans.status = ST_RANGE;
    end else begin
      len = hi - lo + 1;
      lvl = 0;
      while (len > 1) begin
        len = len >> 1;
        lvl++;
      end
      if (lvl >= LEVELS) lvl = LEVELS - 1;
      second = hi + 1 - (1 << lvl);
      if (second < lo) second = lo;
      ans.max_value = greater(window_max[lvl][lo], window_max[lvl][second]);
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_answers.delete();
      element_total = 0;
      mismatches    = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // A result can never belong to the request taken at the same edge.
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_answers.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transfer with no request outstanding", $realtime);
          mismatches++;
        end else begin
          oldest = pending_answers.pop_front();
          if (oldest.max_value !== rsp_i.max_value || oldest.status !== rsp_i.status) begin
            if (mismatches < 10)
              $display("%0t: max_value exp %0d got %0d, status exp %0d got %0d",
                       $realtime, oldest.max_value, rsp_i.max_value,
                       oldest.status, rsp_i.status);
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        pending_answers.push_back(answer_request(req_i.op, req_i.value,
                                                 req_i.left, req_i.right));
      pending_o    <= pending_answers.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

// ===== dv/tb_sparse_table_range_max.sv =====
// ----------------------------------------------------------------------------
// Sparse table range maximum: testbench top
// Sends appends and range queries in random bursts, with a directed opening
// over extreme values, ties, an empty table and bad ranges, while the
// result side stalls on a shifting pattern. The checker alongside the block
// predicts every result; this module only drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_sparse_table_range_max;

  timeunit 1ns;
  timeprecision 1ps;

  import srm_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned LEVELS       = LEVELS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam logic signed [VALUE_W-1:0] MAX_VAL = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] MIN_VAL = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic        [INDEX_W-1:0] TOP_IDX = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        hold_req = 1'b0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned appended;

  srm_in_if  req_if ();
  srm_out_if res_if ();

  sparse_table_range_max #(
    .DEPTH      (DEPTH),
    .LEVELS     (LEVELS),
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  srm_result_checker #(
    .DEPTH  (DEPTH),
    .LEVELS (LEVELS)
  ) u_result_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (res_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9, 0))
      0:       return MAX_VAL;
      1:       return MIN_VAL;
      2, 3, 4: return VALUE_W'($signed($urandom_range(16, 0)) - 8);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic offer(
    input logic                      op,
    input logic signed [VALUE_W-1:0] val,
    input logic        [INDEX_W-1:0] lo,
    input logic        [INDEX_W-1:0] hi
  );
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.value <= val;
    req_if.left  <= lo;
    req_if.right <= hi;
    if (op == OP_APPEND && appended < DEPTH) appended++;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic offer_query();
    int unsigned lo;
    int unsigned hi;
    if (appended == 0 || $urandom_range(99, 0) < 15) begin
      lo = $urandom_range(TOP_IDX, 0);
      hi = $urandom_range(TOP_IDX, 0);
    end else begin
      hi = $urandom_range(appended - 1, 0);
      case ($urandom_range(2, 0))
        0:       lo = hi - $urandom_range((hi < 7) ? hi : 7, 0);
        1:       lo = $urandom_range(hi, 0);
        default: lo = 0;
      endcase
    end
    offer(OP_QUERY, VALUE_W'($urandom), INDEX_W'(lo), INDEX_W'(hi));
  endtask

  // Result side: one long hold-off on request, otherwise a pattern that
  // changes in turn through four modes, including a stretch with no stalls at all.
  initial begin
    int unsigned tick;
    int unsigned hold_left;
    bit          hold_used;
    tick      = 0;
    hold_left = 0;
    hold_used = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case ((tick / 150) % 4)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= 1'($urandom_range(1, 0));
          2:       res_if.ready <= (tick % 5) != 0;
          default: res_if.ready <= $urandom_range(3, 0) == 0;
        endcase
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    bit          paused;
    bit          pause_due;
    appended     = 0;
    burst_left   = 0;
    paused       = 1'b0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.op    = OP_APPEND;
    req_if.value = '0;
    req_if.left  = '0;
    req_if.right = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(OP_QUERY, '0, '0, '0);
    offer(OP_APPEND, MAX_VAL, TOP_IDX, TOP_IDX);
    offer(OP_APPEND, MIN_VAL, '0, '0);
    offer(OP_APPEND, '0, '0, '0);
    offer(OP_APPEND, '1, '0, '0);
    offer(OP_APPEND, 5, '0, '0);
    offer(OP_APPEND, 5, '0, '0);
    offer(OP_APPEND, -7, '0, '0);
    offer(OP_QUERY, '1, 0, 0);
    offer(OP_QUERY, '0, 1, 1);
    offer(OP_QUERY, '0, 0, 6);
    offer(OP_QUERY, '0, 1, 3);
    offer(OP_QUERY, '0, 2, 5);
    offer(OP_QUERY, '0, 4, 5);
    offer(OP_QUERY, '0, 6, 6);
    offer(OP_QUERY, '0, 5, 2);
    offer(OP_QUERY, '0, 0, 7);
    offer(OP_QUERY, '0, TOP_IDX, TOP_IDX);
    offer(OP_QUERY, '0, 0, TOP_IDX);
    offer(OP_QUERY, '0, 3, 6);

    hold_req <= 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        gap       = $urandom_range(8, 0);
        pause_due = !paused && i >= RANDOM_ITEMS / 2;
        if (pause_due && gap == 0) gap = 1;
        if (gap > 0) begin
          req_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
          if (pause_due) begin
            paused = 1'b1;
            while (pending != 0) @(posedge clk_i);
          end
        end
        burst_left = $urandom_range(24, 1);
      end
      burst_left--;
      if ($urandom_range(99, 0) < 75)
        offer(OP_APPEND, pick_value(), INDEX_W'($urandom), INDEX_W'($urandom));
      else
        offer_query();
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/srm_pkg.sv
rtl/srm_if.sv
rtl/srm_mem.sv
rtl/srm_seq.sv
rtl/sparse_table_range_max.sv
dv/srm_result_checker.sv
dv/tb_sparse_table_range_max.sv
